### sv/nsim_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence id matcher package
// Character codes, identifier letter table and shared types.
// ----------------------------------------------------------------------------
package nsim_pkg;

	localparam int ID_COUNT = 6;
	localparam int ID_LEN   = 5;
	localparam int WORD_MAX = 6;
	localparam int POS_W    = 3;
	localparam int TOK_W    = 3;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_NUL    = 8'h00;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_P      = 8'h50;
	localparam logic [7:0] CHAR_N      = 8'h4E;
	localparam logic [7:0] CHAR_S      = 8'h53;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_V      = 8'h56;
	localparam logic [7:0] CHAR_B      = 8'h42;
	localparam logic [7:0] CHAR_O      = 8'h4F;
	localparam logic [7:0] CHAR_D      = 8'h44;
	localparam logic [7:0] CHAR_T      = 8'h54;
	localparam logic [7:0] CHAR_C      = 8'h43;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_MAX - 1);
	localparam logic [POS_W-1:0] ID_END   = POS_W'(ID_LEN);
	localparam logic [ID_COUNT-1:0] ALL_IDS = {ID_COUNT{1'b1}};

	// Identifier letters: GPGGA, GNGSA, GPGSV, GPBOD, GPDBT, GPDCN
	localparam logic [7:0] ID_LETTERS [ID_COUNT][ID_LEN] = '{
		'{CHAR_G, CHAR_P, CHAR_G, CHAR_G, CHAR_A},
		'{CHAR_G, CHAR_N, CHAR_G, CHAR_S, CHAR_A},
		'{CHAR_G, CHAR_P, CHAR_G, CHAR_S, CHAR_V},
		'{CHAR_G, CHAR_P, CHAR_B, CHAR_O, CHAR_D},
		'{CHAR_G, CHAR_P, CHAR_D, CHAR_B, CHAR_T},
		'{CHAR_G, CHAR_P, CHAR_D, CHAR_C, CHAR_N}
	};

	// Outcome of one processed word
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [TOK_W-1:0] tok;
	} nsim_result_t;

	// Mask of identifiers whose letter at position pos equals b
	function automatic logic [ID_COUNT-1:0] letter_keep(
		input logic [POS_W-1:0] pos,
		input logic [7:0]       b
	);
		logic [ID_COUNT-1:0] keep;
		keep = '0;
		for (int i = 0; i < ID_COUNT; i++) begin
			keep[i] = (ID_LETTERS[i][pos] == b);
		end
		return keep;
	endfunction

endpackage

### sv/nsim_word_track.sv
// ----------------------------------------------------------------------------
// NMEA word tracker
// Holds the hunt/collect state and the candidate mask, and judges each word.
// ----------------------------------------------------------------------------
module nsim_word_track import nsim_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   data,
	output nsim_result_t res
);

	logic                collecting_q;
	logic [POS_W-1:0]    position_q;
	logic [ID_COUNT-1:0] candidates_q;
	logic                zero_seen_q;
	logic [POS_W-1:0]    len_zero_q;

	logic                collecting_d;
	logic [POS_W-1:0]    position_d;
	logic [ID_COUNT-1:0] candidates_d;
	logic                zero_seen_d;
	logic [POS_W-1:0]    len_zero_d;
	logic                done;
	logic                is_comma;
	logic [POS_W-1:0]    word_len;
	logic                hit;
	logic [TOK_W-1:0]    tok;

	// Next state for one character
	always_comb begin
		collecting_d = collecting_q;
		position_d   = position_q;
		candidates_d = candidates_q;
		zero_seen_d  = zero_seen_q;
		len_zero_d   = len_zero_q;
		done         = 1'b0;
		is_comma     = (data == CHAR_COMMA);
		if (!collecting_q) begin
			if (data == CHAR_DOLLAR) begin
				collecting_d = 1'b1;
				position_d   = '0;
				candidates_d = ALL_IDS;
				zero_seen_d  = 1'b0;
				len_zero_d   = '0;
			end
		end else if (is_comma) begin
			done = 1'b1;
		end else begin
			if (!zero_seen_q) begin
				if (data == CHAR_NUL) begin
					zero_seen_d = 1'b1;
					len_zero_d  = position_q;
				end else if (position_q < ID_END) begin
					candidates_d = candidates_q & letter_keep(position_q, data);
				end
			end
			if (position_q >= LAST_POS) begin
				done = 1'b1;
			end else begin
				position_d = position_q + 1'b1;
			end
		end
	end

	// Judge the finished word: length, then lowest surviving candidate
	always_comb begin
		priority if (zero_seen_d) begin
			word_len = len_zero_d;
		end else if (is_comma) begin
			word_len = position_q;
		end else begin
			word_len = POS_W'(WORD_MAX);
		end
		hit = (word_len == ID_END) && (candidates_d != '0);
		tok = '0;
		for (int i = ID_COUNT - 1; i >= 0; i--) begin
			if (hit && candidates_d[i]) begin
				tok = TOK_W'(i);
			end
		end
	end

	assign res.done = done;
	assign res.hit  = hit;
	assign res.tok  = tok;

	// Update state; drop back to hunting after each word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			position_q   <= '0;
			candidates_q <= ALL_IDS;
			zero_seen_q  <= 1'b0;
			len_zero_q   <= '0;
		end else if (step) begin
			if (done) begin
				collecting_q <= 1'b0;
				position_q   <= '0;
				candidates_q <= ALL_IDS;
				zero_seen_q  <= 1'b0;
				len_zero_q   <= '0;
			end else begin
				collecting_q <= collecting_d;
				position_q   <= position_d;
				candidates_q <= candidates_d;
				zero_seen_q  <= zero_seen_d;
				len_zero_q   <= len_zero_d;
			end
		end
	end

endmodule

### sv/nmea_sentence_id_matcher.sv
// ----------------------------------------------------------------------------
// NMEA sentence id matcher
// Hunts for '$', collects the identifier word and flags known sentence ids.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one ASCII character per word on data_byte, with
//   in_valid/in_ready. Output channel: matched and token with
//   out_valid/out_ready, one word per finished identifier (ended by ',' or
//   after six characters). Characters outside an identifier give nothing.
//   A character accepted into the input register is judged by the tracker
//   when it advances, and its result is loaded into the result register.
//   Throughput: one character per cycle unless out_ready stalls, set by the
//   single input register feeding the tracker and the single result register.
//   Reset (arst_n low) empties both registers and returns the tracker to
//   hunting for '$'.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more character; in_ready then drops until
//   out_ready returns.
// ----------------------------------------------------------------------------
module nmea_sentence_id_matcher import nsim_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             matched,
	output logic [TOK_W-1:0] token
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             out_valid_q;
	logic             matched_q;
	logic [TOK_W-1:0] token_q;
	logic             advance;
	nsim_result_t     res;

	// Process the held character when the result slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	nsim_word_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (data_s1),
		.res    (res)
	);

	// Result register: load on a finished word, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.done) begin
			matched_q <= res.hit;
			token_q   <= res.tok;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign token     = token_q;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// NMEA sentence id matcher testbench
// Drives serial characters through the valid/ready input, predicts each
// finished identifier word and checks matched/token on the output side,
// with random gaps on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb;
	import nsim_pkg::*;

	localparam int WORD_TARGET = 650;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_OFF    = 80;
	localparam int SHOW_MAX    = 10;

	typedef struct {
		logic             hit;
		logic [TOK_W-1:0] tok;
	} id_verdict_t;

	// Tracks the identifier word in flight and queues the verdicts it yields
	class sentence_id_tracker;
		string            id_text [ID_COUNT];
		bit               collecting;
		logic [POS_W-1:0] position;
		logic [ID_COUNT-1:0] candidates;
		bit               zero_seen;
		logic [POS_W-1:0] length_at_zero;
		id_verdict_t      due_verdicts [$];
		int               error_count;

		function new();
			id_text = '{"GPGGA", "GNGSA", "GPGSV", "GPBOD", "GPDBT", "GPDCN"};
			error_count = 0;
			restart();
		endfunction

		function void restart();
			collecting     = 1'b0;
			position       = '0;
			candidates     = ALL_IDS;
			zero_seen      = 1'b0;
			length_at_zero = '0;
		endfunction

		// Advance the word tracker by one accepted character
		function void note_byte(logic [7:0] b);
			bit                  done;
			int                  len;
			logic [ID_COUNT-1:0] keep;
			id_verdict_t         v;
			done  = 1'b0;
			v.hit = 1'b0;
			v.tok = '0;
			if (!collecting) begin
				if (b == CHAR_DOLLAR) begin
					restart();
					collecting = 1'b1;
				end
				return;
			end
			if (b == CHAR_COMMA) begin
				done = 1'b1;
			end else begin
				if (!zero_seen) begin
					if (b == CHAR_NUL) begin
						zero_seen      = 1'b1;
						length_at_zero = position;
					end else if (position < ID_LEN) begin
						keep = '0;
						for (int i = 0; i < ID_COUNT; i++) begin
							keep[i] = (id_text[i][position] == b);
						end
						candidates &= keep;
					end
				end
				if (int'(position) + 1 >= WORD_MAX) begin
					done = 1'b1;
				end else begin
					position = position + 1'b1;
				end
			end
			if (!done) begin
				return;
			end
			if (zero_seen) begin
				len = length_at_zero;
			end else if (b == CHAR_COMMA) begin
				len = position;
			end else begin
				len = WORD_MAX;
			end
			if (len == ID_LEN) begin
				for (int i = ID_COUNT - 1; i >= 0; i--) begin
					if (candidates[i]) begin
						v.hit = 1'b1;
						v.tok = TOK_W'(i);
					end
				end
			end
			due_verdicts.push_back(v);
			restart();
		endfunction

		function void flag(string msg);
			error_count++;
			if (error_count <= SHOW_MAX) begin
				$display("ERROR: %s", msg);
			end
		endfunction

		// Compare one output word against the oldest verdict
		function void check_word(logic hit, logic [TOK_W-1:0] tok);
			id_verdict_t v;
			if (due_verdicts.size() == 0) begin
				flag($sformatf("unexpected word matched=%0b token=%0d", hit, tok));
				return;
			end
			v = due_verdicts.pop_front();
			if (hit !== v.hit) begin
				flag($sformatf("matched: expected %0b, got %0b", v.hit, hit));
			end
			if (tok !== v.tok) begin
				flag($sformatf("token: expected %0d, got %0d", v.tok, tok));
			end
		endfunction

		function int pending();
			return due_verdicts.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       data_byte;
	logic             out_valid;
	logic             out_ready;
	logic             matched;
	logic [TOK_W-1:0] token;

	sentence_id_tracker tracker;
	bit                 hold_off_req;
	bit                 tight;
	int                 cycle_count;
	int                 word_bytes;

	nmea_sentence_id_matcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched),
		.token     (token)
	);

	// Clock
	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle limit
	initial begin
		cycle_count = 0;
	end
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("nmea_sentence_id_matcher test failed");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Offer one character, hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tight ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid  <= 1'b0;
			data_byte <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_byte(b);
	endtask

	task automatic send_id(input int id, input logic [7:0] term);
		send_byte(CHAR_DOLLAR);
		for (int i = 0; i < ID_LEN; i++) begin
			send_byte(tracker.id_text[id][i]);
		end
		send_byte(term);
	endtask

	function automatic logic [7:0] any_but_comma();
		logic [7:0] b;
		do begin
			b = 8'($urandom);
		end while (b == CHAR_COMMA);
		return b;
	endfunction

	// Build and send one random word; noise bytes do not count
	task automatic send_random_word();
		logic [7:0] body [$];
		string      pool;
		int         kind;
		int         id;
		int         cut;
		int         r;
		pool = "GPNSAVBODTC";
		kind = $urandom_range(0, 99);
		id   = $urandom_range(0, ID_COUNT - 1);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			return;
		end
		if (kind < 50) begin
			// full identifier, sometimes with one letter changed
			for (int i = 0; i < ID_LEN; i++) begin
				body.push_back(tracker.id_text[id][i]);
			end
			if ($urandom_range(0, 3) == 0) begin
				body[$urandom_range(0, ID_LEN - 1)] = pool[$urandom_range(0, pool.len() - 1)];
			end
			r = $urandom_range(0, 99);
			if (r >= 85) begin
				body.push_back(any_but_comma());
			end else if (r >= 70) begin
				body.push_back(CHAR_NUL);
			end
		end else if (kind < 65) begin
			// truncated identifier
			cut = $urandom_range(0, ID_LEN);
			for (int i = 0; i < cut; i++) begin
				body.push_back(tracker.id_text[id][i]);
			end
		end else if (kind < 80) begin
			// zero cuts the compared part, more bytes follow
			cut = $urandom_range(0, ID_LEN);
			for (int i = 0; i < cut; i++) begin
				body.push_back(tracker.id_text[id][i]);
			end
			body.push_back(CHAR_NUL);
			repeat ($urandom_range(0, WORD_MAX - body.size())) body.push_back(any_but_comma());
		end else begin
			repeat (WORD_MAX) body.push_back(8'($urandom));
		end
		if (body.size() < WORD_MAX) begin
			body.push_back(CHAR_COMMA);
		end
		send_byte(CHAR_DOLLAR);
		foreach (body[i]) begin
			send_byte(body[i]);
		end
		word_bytes += body.size() + 1;
	endtask

	// Receiver: random stalls, long ready stretches, hold-off on request
	initial begin
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left   = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF;
				run_left     = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				out_ready <= 1'b1;
				run_left--;
			end else begin
				out_ready  <= 1'b1;
				run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
					: $urandom_range(0, 15);
				stall_left = pick_gap();
			end
		end
	end

	// Check every word taken from the output
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_word(matched, token);
		end
	end

	// Stimulus
	initial begin
		tracker      = new();
		hold_off_req = 1'b0;
		tight        = 1'b0;
		word_bytes   = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// noise while hunting, extremes included
		send_byte(8'hFF);
		send_byte(CHAR_NUL);
		send_byte(CHAR_G);
		// plain match ended by comma
		send_id(0, CHAR_COMMA);
		// zero cuts a six byte word to five letters
		send_id(5, CHAR_NUL);
		// six bytes, no comma, no zero
		send_id(2, CHAR_A);
		// empty word
		send_byte(CHAR_DOLLAR);
		send_byte(CHAR_COMMA);
		// dollar inside a word, zero early, bytes after zero
		send_byte(CHAR_DOLLAR);
		send_byte(CHAR_DOLLAR);
		send_byte(CHAR_G);
		send_byte(CHAR_NUL);
		send_byte(8'hFF);
		send_byte(CHAR_COMMA);

		// back-to-back words against a long hold-off
		tight        = 1'b1;
		hold_off_req = 1'b1;
		send_id(1, CHAR_COMMA);
		send_id(3, CHAR_COMMA);
		send_id(4, CHAR_COMMA);
		tight = 1'b0;

		while (word_bytes < WORD_TARGET) begin
			if ($urandom_range(0, 59) == 0) begin
				tight        = 1'b1;
				hold_off_req = 1'b1;
				repeat (4) send_random_word();
				tight = 1'b0;
			end else begin
				send_random_word();
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.error_count == 0) begin
			$display("nmea_sentence_id_matcher test passed");
		end else begin
			$display("nmea_sentence_id_matcher test failed");
		end
		$finish;
	end

endmodule
